// ----- design/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// ght_pkg - generational handle table shared definitions
// Sizes, handle layout, operation and status codes, memory word types.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOT_COUNT      = 1024;
  localparam int GEN_BITS        = 8;
  localparam int SLOT_BITS       = $clog2(SLOT_COUNT);
  localparam int CNT_BITS        = $clog2(SLOT_COUNT + 1);

  // handle layout: generation field above, slot plus one below
  localparam int HANDLE_BITS     = 32;
  localparam int GEN_SHIFT       = 24;
  localparam int SLOT_FIELD_BITS = 24;
  localparam int GEN_FIELD_BITS  = HANDLE_BITS - GEN_SHIFT;
  localparam int LIVE_BITS       = 11;
  localparam int REV_BITS        = 32;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_DEAD = 2'd2,
    STAT_RSVD = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [GEN_BITS-1:0] gen;
    logic                alive;
  } slot_word_t;

  // free stack entry carries the generation the slot will be issued with
  typedef struct packed {
    logic [GEN_BITS-1:0]  gen;
    logic [SLOT_BITS-1:0] slot;
  } stack_word_t;

endpackage

// ----- design/ght_ram.sv -----
// ----------------------------------------------------------------------------
// ght_ram - simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/generational_handle_table_top.sv -----
// ----------------------------------------------------------------------------
// generational_handle_table_top - generational slot map
// Issues handles {generation, slot+1}, checks and retires them; slots are
// reused from a LIFO free stack, else taken fresh until capacity.
// ----------------------------------------------------------------------------
//
//  channel  | tdata (low bit up)                          | tuser
//  ---------+---------------------------------------------+-----------
//  in_      | handle[31:0]                                | mode[1:0]
//  out_     | new_handle[31:0], live_count[42:32],        | status[1:0]
//           | revision[74:43], 5 pad bits                 |
//
//  Per word: the accept cycle reads both the slot memory (for remove,
//  query) and the free stack (for add); in the execute state the block
//  checks, writes back and loads the output register, since those memories
//  give registered read data. One word is in work at a time.
//  Reset clears control and counters only; slots at or above the fresh-slot
//  count are treated as never used, so no clearing pass is run.
//  A held result stalls the execute cycle; a new word is taken while the
//  previous result still waits in the output register.
//
module generational_handle_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // handle[31:0]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // new_handle, live_count, revision, pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int SLOT_W  = $bits(ght_pkg::slot_word_t);
  localparam int STACK_W = $bits(ght_pkg::stack_word_t);

  // control
  ght_pkg::state_t state_r, state_nxt;
  logic            in_fire;
  logic            exec_go;

  // item captured at accept
  ght_pkg::mode_t                          mode_r;
  logic [ght_pkg::GEN_FIELD_BITS-1:0]      hgen_r;
  logic [ght_pkg::SLOT_BITS-1:0]           slot_r;
  logic                                    in_range_r;

  // counters
  logic [ght_pkg::CNT_BITS-1:0] free_top_r, free_top_nxt;
  logic [ght_pkg::CNT_BITS-1:0] used_r, used_nxt;
  logic [ght_pkg::CNT_BITS-1:0] live_r, live_nxt;
  logic [ght_pkg::REV_BITS-1:0] rev_r, rev_nxt;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  ght_pkg::status_t                out_status_r, out_status_nxt;
  logic [ght_pkg::HANDLE_BITS-1:0] out_handle_r, out_handle_nxt;
  logic [ght_pkg::LIVE_BITS-1:0]   out_live_r, out_live_nxt;
  logic [ght_pkg::REV_BITS-1:0]    out_rev_r, out_rev_nxt;

  // accept-side decode
  logic [ght_pkg::SLOT_FIELD_BITS-1:0] in_field;
  logic [ght_pkg::SLOT_FIELD_BITS-1:0] in_slot_full;
  logic                                in_range;
  logic [ght_pkg::CNT_BITS-1:0]        top_m1;

  // memory ports
  ght_pkg::slot_word_t  slot_rd, slot_wd;
  ght_pkg::stack_word_t stk_rd, stk_wd;
  logic                 slot_we, stk_we;
  logic [ght_pkg::SLOT_BITS-1:0] slot_wa, stk_wa;

  // execute-side
  logic                          hit;
  logic [ght_pkg::GEN_BITS-1:0]  gen_bumped;
  logic [ght_pkg::SLOT_BITS-1:0] add_slot;
  logic [ght_pkg::GEN_BITS-1:0]  add_gen;

  assign in_tready = (state_r == ght_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign exec_go   = (state_r == ght_pkg::ST_EXEC) && (!out_valid_r || out_tready);

  assign in_field     = in_tdata[ght_pkg::SLOT_FIELD_BITS-1:0];
  assign in_slot_full = in_field - 1'b1;
  assign in_range     = (in_field != '0) &&
                        (in_slot_full < ght_pkg::SLOT_FIELD_BITS'(used_r));
  assign top_m1       = free_top_r - 1'b1;

  ght_ram #(
    .DATA_W (SLOT_W),
    .DEPTH  (ght_pkg::SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_wa),
    .wdata (slot_wd),
    .re    (in_fire),
    .raddr (in_slot_full[ght_pkg::SLOT_BITS-1:0]),
    .rdata (slot_rd)
  );

  ght_ram #(
    .DATA_W (STACK_W),
    .DEPTH  (ght_pkg::SLOT_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_wa),
    .wdata (stk_wd),
    .re    (in_fire),
    .raddr (top_m1[ght_pkg::SLOT_BITS-1:0]),
    .rdata (stk_rd)
  );

  // capture of the accepted word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r     <= ght_pkg::mode_t'(in_tuser);
      hgen_r     <= in_tdata[ght_pkg::HANDLE_BITS-1:ght_pkg::GEN_SHIFT];
      slot_r     <= in_slot_full[ght_pkg::SLOT_BITS-1:0];
      in_range_r <= in_range;
    end
  end

  // handle is live: in range, alive, and full generation field matches
  assign hit = in_range_r && slot_rd.alive &&
               (hgen_r == ght_pkg::GEN_FIELD_BITS'(slot_rd.gen));
  assign gen_bumped = ght_pkg::GEN_BITS'(slot_rd.gen + 1'b1);

  always_comb begin
    state_nxt      = state_r;
    free_top_nxt   = free_top_r;
    used_nxt       = used_r;
    live_nxt       = live_r;
    rev_nxt        = rev_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_live_nxt   = out_live_r;
    out_rev_nxt    = out_rev_r;
    slot_we        = 1'b0;
    slot_wa        = slot_r;
    slot_wd        = '0;
    stk_we         = 1'b0;
    stk_wa         = free_top_r[ght_pkg::SLOT_BITS-1:0];
    stk_wd         = '0;
    add_slot       = stk_rd.slot;
    add_gen        = stk_rd.gen;

    unique case (state_r)
      ght_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ght_pkg::ST_EXEC;
        end
      end
      ght_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_nxt      = ght_pkg::ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ght_pkg::STAT_OK;
          out_handle_nxt = '0;
          if (mode_r == ght_pkg::MODE_ADD) begin
            priority if (free_top_r != '0) begin
              // reuse most recently freed slot
              free_top_nxt = top_m1;
            end else if (used_r < ght_pkg::CNT_BITS'(ght_pkg::SLOT_COUNT)) begin
              add_slot = used_r[ght_pkg::SLOT_BITS-1:0];
              add_gen  = '0;
              used_nxt = used_r + 1'b1;
            end else begin
              out_status_nxt = ght_pkg::STAT_FULL;
            end
            if (out_status_nxt == ght_pkg::STAT_OK) begin
              slot_we        = 1'b1;
              slot_wa        = add_slot;
              slot_wd.gen    = add_gen;
              slot_wd.alive  = 1'b1;
              live_nxt       = live_r + 1'b1;
              rev_nxt        = rev_r + 1'b1;
              out_handle_nxt = {ght_pkg::GEN_FIELD_BITS'(add_gen),
                                ght_pkg::SLOT_FIELD_BITS'(add_slot) + 1'b1};
            end
          end else if (mode_r == ght_pkg::MODE_REMOVE) begin
            if (hit) begin
              slot_we       = 1'b1;
              slot_wd.gen   = gen_bumped;
              slot_wd.alive = 1'b0;
              if (free_top_r < ght_pkg::CNT_BITS'(ght_pkg::SLOT_COUNT)) begin
                stk_we       = 1'b1;
                stk_wd.gen   = gen_bumped;
                stk_wd.slot  = slot_r;
                free_top_nxt = free_top_r + 1'b1;
              end
              if (live_r != '0) begin
                live_nxt = live_r - 1'b1;
              end
              rev_nxt = rev_r + 1'b1;
            end else begin
              out_status_nxt = ght_pkg::STAT_DEAD;
            end
          end else begin
            // query, and the spare code acts as one
            if (!hit) begin
              out_status_nxt = ght_pkg::STAT_DEAD;
            end
          end
          out_live_nxt = ght_pkg::LIVE_BITS'(live_nxt);
          out_rev_nxt  = rev_nxt;
        end
      end
      default: state_nxt = ght_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ght_pkg::ST_IDLE;
      free_top_r  <= '0;
      used_r      <= '0;
      live_r      <= '0;
      rev_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_top_r  <= free_top_nxt;
      used_r      <= used_nxt;
      live_r      <= live_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_live_r   <= out_live_nxt;
    out_rev_r    <= out_rev_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'd0, out_rev_r, out_live_r, out_handle_r};

  // every issued slot is either live or parked on the free stack
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r + free_top_r) == used_r)
    else $error("live plus free does not match used slots");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_top_r <= used_r)
    else $error("free stack deeper than used slots");

  a_rev_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ght_pkg::ST_IDLE) |=> $stable(rev_r))
    else $error("revision moved outside execute");

  a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_handle_r != '0)) |-> (out_status_r == ght_pkg::STAT_OK))
    else $error("handle issued with failing status");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ght_pkg::ST_EXEC) |-> !in_tready)
    else $error("word accepted during execute");

endmodule
